// ===== design/scfr_pkg.sv =====
// Shared types and constants for the sync/checksum frame receiver.
`default_nettype none

package scfr_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CHAN_W = 16;

    localparam logic [BYTE_W-1:0] FIRST_SYNC_RST  = 8'h69;
    localparam logic [BYTE_W-1:0] SECOND_SYNC_RST = 8'h7f;

    localparam logic REG_FIRST_SYNC  = 1'b0;
    localparam logic REG_SECOND_SYNC = 1'b1;

    typedef struct packed {
        logic              valid;
        logic [CHAN_W-1:0] channel_a;
        logic [CHAN_W-1:0] channel_b;
    } result_t;

endpackage

`default_nettype wire

// ===== design/scfr_parser.sv =====
// Frame parser: sync registers, frame position, payload store and checksum check.
`default_nettype none

module scfr_parser
    import scfr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic              cfg_index,
    input  wire logic [BYTE_W-1:0] cfg_data,
    input  wire logic              accept,
    input  wire logic [BYTE_W-1:0] rx_byte,
    output result_t                result
);

    typedef enum logic [2:0] {
        POS_HUNT  = 3'd0,
        POS_SYNC2 = 3'd1,
        POS_PL0   = 3'd2,
        POS_PL1   = 3'd3,
        POS_PL2   = 3'd4,
        POS_PL3   = 3'd5,
        POS_CSUM  = 3'd6
    } pos_t;

    logic [BYTE_W-1:0] first_sync_reg;
    logic [BYTE_W-1:0] second_sync_reg;
    pos_t              pos_reg;
    pos_t              pos_next;
    logic              second_ok_reg;
    logic              second_ok_next;
    logic [BYTE_W-1:0] payload_reg [4];
    logic [1:0]        payload_idx;
    logic [BYTE_W-1:0] sum;
    logic              payload_we;

    assign payload_idx = 2'(pos_reg - POS_PL0);
    assign sum = payload_reg[0] + payload_reg[1] + payload_reg[2] + payload_reg[3];

    always_comb
    begin
        pos_next       = pos_reg;
        second_ok_next = second_ok_reg;
        payload_we     = 1'b0;
        result.valid     = 1'b0;
        result.channel_a = {payload_reg[0], payload_reg[1]};
        result.channel_b = {payload_reg[2], payload_reg[3]};
        if (accept)
        begin
            unique case (pos_reg)
                POS_SYNC2:
                begin
                    second_ok_next = (rx_byte == second_sync_reg);
                    pos_next       = POS_PL0;
                end
                POS_PL0, POS_PL1, POS_PL2, POS_PL3:
                begin
                    payload_we = 1'b1;
                    pos_next   = pos_t'(pos_reg + 3'd1);
                end
                POS_CSUM:
                begin
                    result.valid   = second_ok_reg && (sum == rx_byte);
                    second_ok_next = 1'b0;
                    pos_next       = POS_HUNT;
                end
                default:
                begin
                    pos_next = (rx_byte == first_sync_reg) ? POS_SYNC2 : POS_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_sync_reg  <= FIRST_SYNC_RST;
            second_sync_reg <= SECOND_SYNC_RST;
            pos_reg         <= POS_HUNT;
            second_ok_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_FIRST_SYNC)
            begin
                first_sync_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == REG_SECOND_SYNC)
            begin
                second_sync_reg <= cfg_data;
            end
            pos_reg       <= pos_next;
            second_ok_reg <= second_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (payload_we)
        begin
            payload_reg[payload_idx] <= rx_byte;
        end
    end

    a_csum_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && pos_reg == POS_CSUM) |=> (pos_reg == POS_HUNT && !second_ok_reg))
        else $error("frame did not end after checksum byte");

    a_result_needs_header: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (accept && pos_reg == POS_CSUM && second_ok_reg))
        else $error("result without a complete good header");

    a_hunt_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && pos_reg == POS_HUNT && rx_byte != first_sync_reg
            && !(cfg_we && cfg_index == REG_FIRST_SYNC))
        |=> (pos_reg == POS_HUNT))
        else $error("left hunting without first sync byte");

endmodule

`default_nettype wire

// ===== design/scfr_out_reg.sv =====
// Result register between the parser and the output stream.
`default_nettype none

module scfr_out_reg
    import scfr_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                load,
    input  wire result_t             result,
    output logic                     ready,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [2*CHAN_W-1:0]      m_tdata
);

    logic              valid_reg;
    logic              valid_next;
    logic [CHAN_W-1:0] chan_a_reg;
    logic [CHAN_W-1:0] chan_b_reg;

    assign ready      = !valid_reg || m_tready;
    assign valid_next = load ? result.valid : (valid_reg && !m_tready);
    assign m_tvalid   = valid_reg;
    assign m_tdata    = {chan_b_reg, chan_a_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && result.valid)
        begin
            chan_a_reg <= result.channel_a;
            chan_b_reg <= result.channel_b;
        end
    end

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (load && result.valid) |=> valid_reg)
        else $error("result lost on load");

    a_load_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (load && !result.valid) |=> !valid_reg)
        else $error("stale result after empty load");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !m_tready) |-> !load)
        else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== design/sync_checksum_frame_receiver.sv =====
// Top level of the sync/checksum frame receiver.
`default_nettype none

// Takes one received byte per transaction and finds 7-byte frames: first sync,
// second sync, four payload bytes and a checksum equal to the payload sum
// modulo 256. After a first sync byte six more bytes are always consumed. A
// frame with matching second sync and checksum yields one output transaction
// with two big-endian 16-bit channels. A byte can be accepted every cycle;
// input ready drops only while a result waits in the output register and the
// sink is not ready.

module sync_checksum_frame_receiver
    import scfr_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic                cfg_index,
    input  wire logic [BYTE_W-1:0]   cfg_data,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [BYTE_W-1:0]   s_tdata,    // [7:0] rx_byte
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [2*CHAN_W-1:0]      m_tdata     // [15:0] channel_a, [31:16] channel_b
);

    result_t result;
    logic    accept;

    assign accept = s_tvalid && s_tready;

    scfr_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .rx_byte   (s_tdata),
        .result    (result)
    );

    scfr_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .result   (result),
        .ready    (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
